/* hdl/tcw_pkg.sv */
// Shared types and constants of the text console writer.
package tcw_pkg;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] ch;
  } cell_t;

  typedef enum logic [5:0] {
    ST_INIT      = 6'b000001,
    ST_IDLE      = 6'b000010,
    ST_RD_WAIT   = 6'b000100,
    ST_SCR_PRIME = 6'b001000,
    ST_SCROLL    = 6'b010000,
    ST_CLEAR     = 6'b100000
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0]  pos;
    logic              scrolled;
    logic [CHAR_W-1:0] rd_char;
    logic [ATTR_W-1:0] rd_attr;
    logic              done;
  } rsp_t;

endpackage

/* hdl/tcw_if.sv */
// Channel interfaces of the text console writer: command, response, configuration.
interface tcw_cmd_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;
  logic              last_char;
  modport source (output valid, operation, char_code, cell_index, last_char, input ready);
  modport sink   (input valid, operation, char_code, cell_index, last_char, output ready);
endinterface

interface tcw_rsp_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  cursor_position;
  logic              scrolled;
  logic [CHAR_W-1:0] read_char;
  logic [ATTR_W-1:0] read_attribute;
  logic              string_done;
  modport source (output valid, cursor_position, scrolled, read_char, read_attribute,
                  string_done, input ready);
  modport sink   (input valid, cursor_position, scrolled, read_char, read_attribute,
                  string_done, output ready);
endinterface

interface tcw_cfg_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] text_attribute;
  modport source (output valid, text_attribute, input ready);
  modport sink   (input valid, text_attribute, output ready);
endinterface

/* hdl/tcw_screen_ram.sv */
// Screen cell memory: one write port, one read port, registered read data.
module tcw_screen_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  waddr_i,
  input  tcw_pkg::cell_t     wdata_i,
  input  logic               re_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  output tcw_pkg::cell_t     rdata_o
);
  import tcw_pkg::*;

  cell_t mem [DEPTH];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/text_console_writer_top.sv */
// Top level of the text console writer: cursor control, sweeps and result register.
//
// A ROWS x COLUMNS character console. Items arrive on cmd_i (valid/ready):
// write a character at the cursor, clear the screen, or read one cell.
// Every item gives exactly one item on rsp_o carrying the cursor position.
// cfg_i sets the attribute byte used for written and blank cells; it is
// always ready and should only be written while the console is idle.
//
// Steps from accepting an item to the result being valid:
//   write without scroll, unused code, read out of range : result on acceptance
//   read in range                                          : memory read, then result
//   write that scrolls                                     : prime, copy sweep, result
//   clear                                                  : blank sweep, then result
// The single-port-write screen memory shapes these steps: a scroll copies
// one cell per cycle and a clear blanks one cell per cycle.
// A new item is taken once the previous one is finished and the result
// register is empty or being drained in the same cycle, so writes without a
// scroll sustain one item per cycle while rsp_o is ready; a read in range
// is done before the next item is taken. After reset the memory is filled
// with spaces in attribute 0x0F, one cell per cycle; cmd_i is not ready meanwhile.
// A stalled rsp_o holds its item; cmd_i then waits.
module text_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tcw_cmd_if.sink   cmd_i,
  tcw_rsp_if.source rsp_o,
  tcw_cfg_if.sink   cfg_i
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int LAST_BASE  = CELL_COUNT - COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(COLUMNS);
  localparam int PW         = ((AW > IDX_W) ? AW : IDX_W) + 1;

  state_e          state_q, state_d;
  logic [AW-1:0]   pos_q, pos_d;     // cursor cell number
  logic [CW-1:0]   col_q, col_d;     // cursor column
  logic [AW-1:0]   swp_q, swp_d;     // sweep counter for fill and scroll
  logic [ATTR_W-1:0] attr_q;
  logic            done_q, done_d;   // last_char of a scrolling write
  logic            rsp_valid_q;
  rsp_t            rsp_q, rsp_d;
  logic            load_rsp;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  cell_t           ram_wdata, ram_rdata, blank_cell;

  logic            cmd_acc;
  op_e             op;
  logic [PW-1:0]   idx_ext;
  logic [PW-1:0]   pos_ext, pos_next_ext;
  logic            idx_in_range;

  tcw_screen_ram #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Take a new item only when idle and the result register frees up.
  assign cmd_i.ready  = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign cmd_acc      = cmd_i.valid && cmd_i.ready;
  assign op           = op_e'(cmd_i.operation);
  assign cfg_i.ready  = 1'b1;

  assign idx_ext      = PW'(cmd_i.cell_index);
  assign idx_in_range = idx_ext < PW'(CELL_COUNT);
  assign pos_ext      = PW'(pos_q);
  assign pos_next_ext = PW'(pos_q + AW'(1));

  assign blank_cell   = '{attr: attr_q, ch: BLANK_CHAR};

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    col_d     = col_q;
    swp_d     = swp_q;
    done_d    = done_q;
    ram_we    = 1'b0;
    ram_waddr = swp_q;
    ram_wdata = blank_cell;
    ram_re    = 1'b0;
    ram_raddr = swp_q + AW'(COLUMNS + 1);
    load_rsp  = 1'b0;
    rsp_d     = '0;
    rsp_d.pos = pos_ext[IDX_W-1:0];

    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        // Blank one cell per cycle; a clear reports when the sweep ends.
        ram_we = 1'b1;
        if (swp_q == AW'(CELL_COUNT - 1)) begin
          load_rsp = (state_q == ST_CLEAR);
          state_d  = ST_IDLE;
        end else begin
          swp_d = swp_q + AW'(1);
        end
      end

      ST_IDLE: begin
        if (cmd_acc) begin
          case (op)
            OP_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = pos_q;
              ram_wdata = '{attr: attr_q, ch: cmd_i.char_code};
              done_d    = cmd_i.last_char;
              if (col_q == CW'(COLUMNS - 1) && pos_q >= AW'(LAST_BASE)) begin
                // Bottom-right cell: scroll before reporting.
                col_d   = '0;
                pos_d   = AW'(LAST_BASE);
                state_d = ST_SCR_PRIME;
              end else begin
                col_d      = (col_q == CW'(COLUMNS - 1)) ? '0 : col_q + CW'(1);
                pos_d      = pos_q + AW'(1);
                load_rsp   = 1'b1;
                rsp_d.pos  = pos_next_ext[IDX_W-1:0];
                rsp_d.done = cmd_i.last_char;
              end
            end
            OP_CLEAR: begin
              pos_d     = '0;
              col_d     = '0;
              swp_d     = '0;
              state_d   = ST_CLEAR;
            end
            OP_READ: begin
              if (idx_in_range) begin
                ram_re    = 1'b1;
                ram_raddr = idx_ext[AW-1:0];
                state_d   = ST_RD_WAIT;
              end else begin
                load_rsp = 1'b1;
              end
            end
            default: begin
              load_rsp = 1'b1;
            end
          endcase
        end
      end

      ST_RD_WAIT: begin
        load_rsp      = 1'b1;
        rsp_d.rd_char = ram_rdata.ch;
        rsp_d.rd_attr = ram_rdata.attr;
        state_d       = ST_IDLE;
      end

      ST_SCR_PRIME: begin
        // Fetch the first cell of row one so the copy can stream.
        ram_re    = 1'b1;
        ram_raddr = AW'(COLUMNS);
        swp_d     = '0;
        state_d   = ST_SCROLL;
      end

      ST_SCROLL: begin
        // Write cell swp from the cell one row below; blank the bottom row.
        ram_we    = 1'b1;
        ram_wdata = (swp_q < AW'(LAST_BASE)) ? ram_rdata : blank_cell;
        ram_re    = (swp_q < AW'(LAST_BASE - 1));
        if (swp_q == AW'(CELL_COUNT - 1)) begin
          load_rsp       = 1'b1;
          rsp_d.scrolled = 1'b1;
          rsp_d.done     = done_q;
          state_d        = ST_IDLE;
        end else begin
          swp_d = swp_q + AW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      pos_q       <= '0;
      col_q       <= '0;
      swp_q       <= '0;
      attr_q      <= RESET_ATTR;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      col_q   <= col_d;
      swp_q   <= swp_d;
      if (cfg_i.valid && cfg_i.ready) begin
        attr_q <= cfg_i.text_attribute;
      end
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    done_q <= done_d;
    if (load_rsp) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.cursor_position = rsp_q.pos;
  assign rsp_o.scrolled        = rsp_q.scrolled;
  assign rsp_o.read_char       = rsp_q.rd_char;
  assign rsp_o.read_attribute  = rsp_q.rd_attr;
  assign rsp_o.string_done     = rsp_q.done;

  // Never overwrite a result that has not been taken.
  a_no_rsp_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_rsp |-> (!rsp_valid_q || rsp_o.ready))
    else $error("result register overwritten");

  // The cursor stays on the screen.
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_ext < PW'(CELL_COUNT))
    else $error("cursor off screen");

  // The streaming copy never reads the cell it writes.
  a_scroll_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL && ram_re) |-> (ram_raddr != ram_waddr))
    else $error("scroll read and write collide");

  // A scroll result always puts the cursor at the start of the bottom row.
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_rsp && rsp_d.scrolled) |=> (rsp_o.cursor_position == IDX_W'(LAST_BASE)
      && pos_q == AW'(LAST_BASE)))
    else $error("scroll left the cursor misplaced");

  // No item is taken while a sweep or read is in flight.
  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_acc) |-> ($past(state_q) == ST_IDLE))
    else $error("item accepted while busy");

endmodule
